// ===== rtl/core/first_fit_heap_allocator_macros.svh =====
// assertion macros for the first-fit heap allocator checker
// expects signals named clock and reset in the scope of use
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFHA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/ffha_pkg.sv =====
// shared types and constants of the first-fit heap allocator
// used by the controller, the datapath, the top level and the checker
`default_nettype none

package ffha_pkg;

   localparam int HEAP_BYTES        = 65536;
   localparam int HDR_BYTES         = 16;
   localparam int MIN_SPLIT_PAYLOAD = 8;
   localparam int SLOTS             = HEAP_BYTES / 8;
   localparam int SLOT_W            = $clog2(SLOTS);
   localparam int MAX_HDR_SLOT      = (HEAP_BYTES - HDR_BYTES) / 8;
   localparam int SPLIT_LIMIT       = HDR_BYTES + MIN_SPLIT_PAYLOAD;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_RESIZE  = 2'd2;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic [15:0]       size;
      logic [SLOT_W-1:0] next;
      logic              has_next;
      logic              used;
   } hdr_type;

   localparam hdr_type RESET_HDR = '{size: 16'(HEAP_BYTES - HDR_BYTES),
                                     next: '0, has_next: 1'b0, used: 1'b0};

   typedef enum logic [1:0] {K_NONE, K_ALLOC, K_RELEASE, K_RESIZE} kind_type;
   typedef enum logic [1:0] {RD_NONE, RD_CUR, RD_LINK} rd_sel_type;
   typedef enum logic [1:0] {B_HOLD, B_ZERO, B_LINK, B_PSLOT} b_sel_type;
   typedef enum logic [1:0] {RES_HOLD, RES_ALLOC, RES_PTR} res_sel_type;

   typedef struct packed {
      logic        load;
      rd_sel_type  rd;
      logic        cap;
      logic        merge;
      logic        wr_bh;
      logic        wr_split;
      logic        set_used;
      logic        clr_used;
      b_sel_type   b_sel;
      res_sel_type res_sel;
      logic        fail;
      logic        cap_copy;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     q_used;
      logic     bh_hn;
      logic     fit_q;
      logic     fit_bh;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/ffha_datapath.sv =====
// datapath of the heap allocator: header memory, current block registers
// and request/result registers; depends on ffha_pkg
`default_nettype none

module ffha_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ffha_pkg::dp_cmd_type cmd,
   input  logic [1:0]           req_operation,
   input  logic [16:0]          req_request_size,
   input  logic [15:0]          req_payload_offset,
   output ffha_pkg::dp_stat_type stat,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_result_offset,
   output logic                 rsp_moved,
   output logic [15:0]          rsp_copy_length
);
   import ffha_pkg::*;

   hdr_type mem [SLOTS];

   hdr_type           q_raw_ff, q, bh_ff, bh_in, bh_wr, sp_hdr, wr_data;
   logic              init_ff, rd_init_ff;
   logic              rd_en, we;
   logic [SLOT_W-1:0] rd_addr, wr_addr, b_ff, b_in, pslot;
   kind_type          kind_ff, kind_dec;
   logic [17:0]       need_ff, need_dec, sp_rem;
   logic [16:0]       size_nz;
   logic [15:0]       ptr_ff, result_ff, copy_ff, sp_slot;
   logic [1:0]        status_ff, status_dec;
   logic              moved_ff, ptr_bad, split_ok;

   // request decode
   always_comb begin
      ptr_bad    = (req_payload_offset < 16'(HDR_BYTES)) || (req_payload_offset[2:0] != 3'd0);
      status_dec = ST_DONE;
      kind_dec   = K_NONE;
      unique case (req_operation)
         OP_ALLOC: kind_dec = K_ALLOC;
         OP_RELEASE: begin
            if (req_payload_offset != 16'd0) begin
               if (ptr_bad) status_dec = ST_INVALID;
               else         kind_dec   = K_RELEASE;
            end
         end
         OP_RESIZE: begin
            if (req_payload_offset == 16'd0) begin
               kind_dec = K_ALLOC;
            end else if (ptr_bad) begin
               status_dec = ST_INVALID;
            end else if (req_request_size == 17'd0) begin
               kind_dec = K_RELEASE;
            end else begin
               kind_dec = K_RESIZE;
            end
         end
         default: status_dec = ST_INVALID;
      endcase
      size_nz  = (req_request_size == 17'd0) ? 17'd1 : req_request_size;
      need_dec = ({1'b0, size_nz} + 18'd7) & ~18'd7;
   end

   assign q     = rd_init_ff ? RESET_HDR : q_raw_ff;
   assign pslot = SLOT_W'(ptr_ff[15:3] - 13'd2);

   // split of the current block
   always_comb begin
      sp_rem   = {2'b0, bh_ff.size} - need_ff;
      sp_slot  = {3'b0, b_ff} + 16'd2 + 16'(need_ff[17:3]);
      split_ok = ({2'b0, bh_ff.size} > need_ff) && (sp_rem > 18'(SPLIT_LIMIT))
                 && (sp_slot <= 16'(MAX_HDR_SLOT));
      sp_hdr          = bh_ff;
      sp_hdr.size     = 16'(sp_rem - 18'(HDR_BYTES));
      sp_hdr.used     = 1'b0;
      bh_wr           = bh_ff;
      if (cmd.set_used) bh_wr.used = 1'b1;
      if (cmd.clr_used) bh_wr.used = 1'b0;
   end

   always_comb begin
      rd_en   = (cmd.rd != RD_NONE);
      rd_addr = (cmd.rd == RD_LINK) ? bh_ff.next : b_ff;
      we      = cmd.wr_bh || (cmd.wr_split && split_ok);
      wr_addr = cmd.wr_split ? sp_slot[SLOT_W-1:0] : b_ff;
      wr_data = cmd.wr_split ? sp_hdr : bh_wr;

      bh_in = bh_ff;
      if (cmd.cap) begin
         bh_in = q;
      end else if (cmd.merge) begin
         bh_in.size     = bh_ff.size + 16'(HDR_BYTES) + q.size;
         bh_in.next     = q.next;
         bh_in.has_next = q.has_next;
      end else if (cmd.wr_bh) begin
         bh_in = bh_wr;
      end else if (cmd.wr_split && split_ok) begin
         bh_in.size     = need_ff[15:0];
         bh_in.next     = sp_slot[SLOT_W-1:0];
         bh_in.has_next = 1'b1;
      end

      unique case (cmd.b_sel)
         B_ZERO:  b_in = '0;
         B_LINK:  b_in = bh_ff.next;
         B_PSLOT: b_in = pslot;
         default: b_in = b_ff;
      endcase
   end

   // header memory
   always_ff @(posedge clock) begin
      if (rd_en) q_raw_ff <= mem[rd_addr];
      if (we) mem[wr_addr] <= wr_data;
   end

   // entry 0 reads as the initial free block until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= 1'b1;
         rd_init_ff <= 1'b0;
      end else begin
         if (we && (wr_addr == '0)) init_ff <= 1'b0;
         if (rd_en) rd_init_ff <= (rd_addr == '0) && init_ff;
      end
   end

   always_ff @(posedge clock) begin
      bh_ff <= bh_in;
      b_ff  <= b_in;
      if (cmd.load) begin
         kind_ff   <= kind_dec;
         need_ff   <= need_dec;
         ptr_ff    <= req_payload_offset;
         status_ff <= status_dec;
         result_ff <= 16'd0;
         moved_ff  <= 1'b0;
         copy_ff   <= 16'd0;
      end else begin
         if (cmd.fail) begin
            status_ff <= ST_NOSPACE;
            result_ff <= 16'd0;
         end
         unique case (cmd.res_sel)
            RES_ALLOC: result_ff <= {b_ff, 3'b0} + 16'(HDR_BYTES);
            RES_PTR:   result_ff <= ptr_ff;
            default:   ;
         endcase
         if (cmd.cap_copy) begin
            copy_ff  <= q.size;
            moved_ff <= 1'b1;
         end
      end
   end

   assign stat.kind   = kind_ff;
   assign stat.q_used = q.used;
   assign stat.bh_hn  = bh_ff.has_next;
   assign stat.fit_q  = {2'b0, q.size} >= need_ff;
   assign stat.fit_bh = {2'b0, bh_ff.size} >= need_ff;

   assign rsp_status        = status_ff;
   assign rsp_result_offset = result_ff;
   assign rsp_moved         = moved_ff;
   assign rsp_copy_length   = copy_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ffha_ctrl.sv =====
// controller of the heap allocator: sequences list walks, merges, splits
// and resize steps; depends on ffha_pkg
`default_nettype none

module ffha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ffha_pkg::dp_stat_type stat,
   output ffha_pkg::dp_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import ffha_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_F_RD, S_F_CAP, S_F_WR, S_W_RD, S_W_CAP, S_W_ADV,
      S_MG_RD, S_MG_CHK, S_MG_END, S_SPLIT, S_SPL_WB, S_R_RD, S_R_CAP,
      S_R_ORD, S_R_OCAP, S_R_OWR
   } state_type;

   state_type state_ff, state_in;
   logic walk_alloc_ff, walk_alloc_in, in_resize_ff, in_resize_in;
   logic mg_resize_ff, mg_resize_in, split_alloc_ff, split_alloc_in;
   logic busy_ff, rsp_valid_ff, finish;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      walk_alloc_in  = walk_alloc_ff;
      in_resize_in   = in_resize_ff;
      mg_resize_in   = mg_resize_ff;
      split_alloc_in = split_alloc_ff;
      finish         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load     = 1'b1;
               in_resize_in = 1'b0;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.kind)
               K_ALLOC: begin
                  cmd.b_sel     = B_ZERO;
                  walk_alloc_in = 1'b1;
                  state_in      = S_W_RD;
               end
               K_RELEASE: begin
                  cmd.b_sel = B_PSLOT;
                  state_in  = S_F_RD;
               end
               K_RESIZE: begin
                  cmd.b_sel    = B_PSLOT;
                  in_resize_in = 1'b1;
                  state_in     = S_R_RD;
               end
               default: finish = 1'b1;
            endcase
         end
         S_F_RD: begin
            cmd.rd   = RD_CUR;
            state_in = S_F_CAP;
         end
         S_F_CAP: begin
            cmd.cap  = 1'b1;
            state_in = S_F_WR;
         end
         S_F_WR: begin
            cmd.wr_bh     = 1'b1;
            cmd.clr_used  = 1'b1;
            cmd.b_sel     = B_ZERO;
            walk_alloc_in = 1'b0;
            state_in      = S_W_RD;
         end
         S_W_RD: begin
            cmd.rd   = RD_CUR;
            state_in = S_W_CAP;
         end
         S_W_CAP: begin
            cmd.cap = 1'b1;
            if (stat.q_used) begin
               state_in = S_W_ADV;
            end else begin
               mg_resize_in = 1'b0;
               state_in     = S_MG_RD;
            end
         end
         S_W_ADV: begin
            if (!stat.bh_hn) begin
               cmd.fail = walk_alloc_ff;
               finish   = 1'b1;
            end else begin
               cmd.b_sel = B_LINK;
               state_in  = S_W_RD;
            end
         end
         S_MG_RD: begin
            if (stat.bh_hn) begin
               cmd.rd   = RD_LINK;
               state_in = S_MG_CHK;
            end else begin
               state_in = S_MG_END;
            end
         end
         S_MG_CHK: begin
            if (stat.q_used) begin
               state_in = S_MG_END;
            end else begin
               cmd.merge = 1'b1;
               state_in  = S_MG_RD;
            end
         end
         S_MG_END: begin
            cmd.wr_bh = 1'b1;
            if (mg_resize_ff) begin
               if (stat.fit_bh) begin
                  split_alloc_in = 1'b0;
                  state_in       = S_SPLIT;
               end else begin
                  cmd.b_sel     = B_ZERO;
                  walk_alloc_in = 1'b1;
                  state_in      = S_W_RD;
               end
            end else if (walk_alloc_ff && stat.fit_bh) begin
               split_alloc_in = 1'b1;
               state_in       = S_SPLIT;
            end else begin
               state_in = S_W_ADV;
            end
         end
         S_SPLIT: begin
            cmd.wr_split = 1'b1;
            state_in     = S_SPL_WB;
         end
         S_SPL_WB: begin
            cmd.wr_bh = 1'b1;
            if (split_alloc_ff) begin
               cmd.set_used = 1'b1;
               cmd.res_sel  = RES_ALLOC;
               if (in_resize_ff) begin
                  cmd.b_sel = B_PSLOT;
                  state_in  = S_R_ORD;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               cmd.res_sel = RES_PTR;
               finish      = 1'b1;
            end
         end
         S_R_RD: begin
            cmd.rd   = RD_CUR;
            state_in = S_R_CAP;
         end
         S_R_CAP: begin
            cmd.cap = 1'b1;
            if (stat.fit_q) begin
               split_alloc_in = 1'b0;
               state_in       = S_SPLIT;
            end else begin
               mg_resize_in = 1'b1;
               state_in     = S_MG_RD;
            end
         end
         S_R_ORD: begin
            cmd.rd   = RD_CUR;
            state_in = S_R_OCAP;
         end
         S_R_OCAP: begin
            cmd.cap      = 1'b1;
            cmd.cap_copy = 1'b1;
            state_in     = S_R_OWR;
         end
         S_R_OWR: begin
            cmd.wr_bh     = 1'b1;
            cmd.clr_used  = 1'b1;
            cmd.b_sel     = B_ZERO;
            walk_alloc_in = 1'b0;
            state_in      = S_W_RD;
         end
         default: state_in = S_IDLE;
      endcase
      if (finish) state_in = S_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         walk_alloc_ff  <= 1'b0;
         in_resize_ff   <= 1'b0;
         mg_resize_ff   <= 1'b0;
         split_alloc_ff <= 1'b0;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         walk_alloc_ff  <= walk_alloc_in;
         in_resize_ff   <= in_resize_in;
         mg_resize_ff   <= mg_resize_in;
         split_alloc_ff <= split_alloc_in;
         busy_ff        <= finish ? 1'b0 : (busy_ff || cmd.load);
         rsp_valid_ff   <= finish;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// a list walk reads each block header from the header memory, which has a registered read;
// a free block visited is merged with its free neighbours and written back; invalid or null
// requests answer from the dispatch state without touching the header memory
// throughput: one transaction at a time, the next start is taken in the result cycle
// reset: synchronous, active high; the heap comes up as one free block, no clearing pass
// results cannot be stalled: rsp_valid marks each result for exactly one cycle
`default_nettype none

module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [16:0] req_request_size,
   input  logic [15:0] req_payload_offset,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_result_offset,
   output logic        rsp_moved,
   output logic [15:0] rsp_copy_length
);
   import ffha_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: one state per memory access of a walk, merge or split
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: header store, current block copy and result registers
   ffha_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_operation),
      .req_request_size   (req_request_size),
      .req_payload_offset (req_payload_offset),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_result_offset  (rsp_result_offset),
      .rsp_moved          (rsp_moved),
      .rsp_copy_length    (rsp_copy_length)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ffha_checker.sv =====
// port-level checks of the heap allocator and their bind to the top level
// depends on ffha_pkg and first_fit_heap_allocator_macros.svh
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_result_offset,
   input logic        rsp_moved
);
   import ffha_pkg::*;

   `FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `FFHA_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid)
   `FFHA_ASSERT_SAME(a_nospace_null, rsp_valid && (rsp_status == ST_NOSPACE), rsp_result_offset == 16'd0)
   `FFHA_ASSERT_SAME(a_moved_ok, rsp_valid && rsp_moved, (rsp_status == ST_DONE) && (rsp_result_offset != 16'd0))

endmodule

bind first_fit_heap_allocator ffha_checker u_chk (.*);

`default_nettype wire

// ===== sim/tb_first_fit_heap_allocator.sv =====
// self-checking testbench of first_fit_heap_allocator: directed table, then random traffic
// depends on ffha_pkg and the first_fit_heap_allocator top level; predicts every result not typed in the table
`default_nettype none

module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam logic [1:0] SEL_LIT    = 2'd0;   // pointer taken from the table
   localparam logic [1:0] SEL_LAST   = 2'd1;   // latest granted payload
   localparam logic [1:0] SEL_PREV   = 2'd2;   // the grant before that
   localparam int RANDOM_ITEMS = 630;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int DIR_ROWS     = 18;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] offset;
      logic        moved;
      logic [15:0] copy;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [16:0] size;
      logic [15:0] ptr;
      logic [1:0]  sel;
      logic        chk;
      logic [1:0]  st;
      logic [15:0] off;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [16:0] req_request_size;
   logic [15:0] req_payload_offset;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_result_offset;
   logic        rsp_moved;
   logic [15:0] rsp_copy_length;

   first_fit_heap_allocator uut (.*);

   always #5 clock = ~clock;

   // shadow of the header store, one entry per 8-byte slot
   int unsigned blk_size [SLOTS];
   int unsigned blk_next [SLOTS];
   bit          blk_linked [SLOTS];
   bit          blk_used [SLOTS];
   bit          slot_written [SLOTS];
   int unsigned written_slots [$];

   rsp_type     pending_rsp [$];
   logic [15:0] live_blocks [$];
   logic [15:0] last_grant, prev_grant;
   int          fail_count;
   int          cycle_count;
   int          burst_left;

   // stimulus table: checked values typed in only where obvious
   dir_row_type dir_tab [0:DIR_ROWS-1] = '{
      '{OP_ALLOC,   17'd0,     16'd0,     SEL_LIT,  1'b1, ST_DONE,    16'd16},
      '{OP_ALLOC,   17'd100,   16'd0,     SEL_LIT,  1'b0, ST_DONE,    16'd0},
      '{OP_ALLOC,   17'd65536, 16'd0,     SEL_LIT,  1'b1, ST_NOSPACE, 16'd0},
      '{OP_RELEASE, 17'd0,     16'd0,     SEL_LIT,  1'b1, ST_DONE,    16'd0},
      '{OP_RELEASE, 17'd0,     16'd3,     SEL_LIT,  1'b1, ST_INVALID, 16'd0},
      '{OP_RELEASE, 17'd0,     16'd8,     SEL_LIT,  1'b1, ST_INVALID, 16'd0},
      '{OP_RESIZE,  17'd64,    16'hffff,  SEL_LIT,  1'b1, ST_INVALID, 16'd0},
      '{OP_UNKNOWN, 17'd65536, 16'hfff8,  SEL_LIT,  1'b1, ST_INVALID, 16'd0},
      '{OP_RESIZE,  17'd24,    16'd0,     SEL_LIT,  1'b0, ST_DONE,    16'd0},
      '{OP_RESIZE,  17'd0,     16'd0,     SEL_LAST, 1'b0, ST_DONE,    16'd0},
      '{OP_RESIZE,  17'd200,   16'd16,    SEL_LIT,  1'b0, ST_DONE,    16'd0},
      '{OP_RESIZE,  17'd8,     16'd16,    SEL_LIT,  1'b0, ST_DONE,    16'd0},
      '{OP_ALLOC,   17'd1,     16'd0,     SEL_LIT,  1'b0, ST_DONE,    16'd0},
      '{OP_ALLOC,   17'd8,     16'd0,     SEL_LIT,  1'b0, ST_DONE,    16'd0},
      '{OP_RESIZE,  17'd4000,  16'd0,     SEL_PREV, 1'b0, ST_DONE,    16'd0},
      '{OP_RELEASE, 17'd0,     16'd0,     SEL_LAST, 1'b0, ST_DONE,    16'd0},
      '{OP_RESIZE,  17'd65536, 16'd16,    SEL_LIT,  1'b0, ST_DONE,    16'd0},
      '{OP_RELEASE, 17'd0,     16'd16,    SEL_LIT,  1'b0, ST_DONE,    16'd0}
   };

   function automatic bit header_fits(int unsigned off);
      return off <= HEAP_BYTES - HDR_BYTES && off[2:0] == 3'd0;
   endfunction

   function automatic int unsigned padded_size(int unsigned s);
      if (s == 0) s = 1;
      return (s + 7) & ~32'd7;
   endfunction

   // absorb the free blocks that follow block b
   function automatic void absorb_free_run(int unsigned b);
      int unsigned n = 0;
      int unsigned i;
      while (blk_linked[b] && n < SLOTS) begin
         if (!header_fits(blk_next[b])) break;
         i = blk_next[b] >> 3;
         if (blk_used[i]) break;
         blk_size[b]   = blk_size[b] + HDR_BYTES + blk_size[i];
         blk_next[b]   = blk_next[i];
         blk_linked[b] = blk_linked[i];
         n++;
      end
   endfunction

   // carve a free remainder off block b when it is worth a header
   function automatic void trim_block(int unsigned b, int unsigned need);
      int unsigned rem, noff, i;
      if (blk_size[b] <= need) return;
      rem = blk_size[b] - need;
      if (rem <= SPLIT_LIMIT) return;
      noff = (b << 3) + HDR_BYTES + need;
      if (!header_fits(noff)) return;
      i = noff >> 3;
      blk_size[i]   = rem - HDR_BYTES;
      blk_next[i]   = blk_next[b];
      blk_linked[i] = blk_linked[b];
      blk_used[i]   = 1'b0;
      if (!slot_written[i]) begin
         slot_written[i] = 1'b1;
         written_slots.push_back(i);
      end
      blk_size[b]   = need;
      blk_next[b]   = noff;
      blk_linked[b] = 1'b1;
   endfunction

   function automatic bit step_list(ref int unsigned b);
      if (!blk_linked[b] || !header_fits(blk_next[b])) return 1'b0;
      b = blk_next[b] >> 3;
      return 1'b1;
   endfunction

   function automatic int unsigned first_fit(int unsigned need);
      int unsigned b = 0;
      for (int unsigned steps = 0; steps <= SLOTS; steps++) begin
         if (!blk_used[b]) begin
            absorb_free_run(b);
            if (blk_size[b] >= need) begin
               trim_block(b, need);
               blk_used[b] = 1'b1;
               return (b << 3) + HDR_BYTES;
            end
         end
         if (!step_list(b)) break;
      end
      return 0;
   endfunction

   function automatic void coalesce_heap();
      int unsigned b = 0;
      for (int unsigned steps = 0; steps <= SLOTS; steps++) begin
         if (!blk_used[b]) absorb_free_run(b);
         if (!step_list(b)) break;
      end
   endfunction

   function automatic bit pointer_slot(int unsigned p, output int unsigned b);
      b = 0;
      if (p < HDR_BYTES || p >= HEAP_BYTES || p[2:0] != 3'd0) return 1'b0;
      b = (p - HDR_BYTES) >> 3;
      return 1'b1;
   endfunction

   // works out one transaction against the shadow heap
   function automatic rsp_type serve_request(logic [1:0] op_in, logic [16:0] size_in,
                                             logic [15:0] ptr_in);
      rsp_type r = '0;
      logic [1:0] op = op_in;
      int unsigned b, need, res = 0;
      if (op == OP_RESIZE && ptr_in == 0) op = OP_ALLOC;
      if (op == OP_RESIZE && size_in == 0) op = OP_RELEASE;
      case (op)
         OP_ALLOC: begin
            res = first_fit(padded_size(size_in));
            if (res == 0) r.status = ST_NOSPACE;
         end
         OP_RELEASE: begin
            if (ptr_in != 0) begin
               if (!pointer_slot(ptr_in, b)) r.status = ST_INVALID;
               else begin
                  blk_used[b] = 1'b0;
                  coalesce_heap();
               end
            end
         end
         OP_RESIZE: begin
            if (!pointer_slot(ptr_in, b)) r.status = ST_INVALID;
            else begin
               need = padded_size(size_in);
               if (blk_size[b] < need) absorb_free_run(b);
               if (blk_size[b] >= need) begin
                  trim_block(b, need);
                  res = ptr_in;
               end else begin
                  res = first_fit(need);
                  if (res == 0) r.status = ST_NOSPACE;
                  else begin
                     r.copy = blk_size[b][15:0];
                     blk_used[b] = 1'b0;
                     coalesce_heap();
                     r.moved = 1'b1;
                  end
               end
            end
         end
         default: r.status = ST_INVALID;
      endcase
      r.offset = res[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d, expected %0d (t=%0t)", field, got, want, $time);
      fail_count++;
   endtask

   function automatic void forget_live(logic [15:0] p);
      foreach (live_blocks[i])
         if (live_blocks[i] == p) begin
            live_blocks.delete(i);
            return;
         end
   endfunction

   // one transaction: hold start until busy is low at an edge, then predict
   task automatic issue(logic [1:0] op, logic [16:0] size, logic [15:0] ptr,
                        bit typed, rsp_type typed_rsp);
      rsp_type pred;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      start              <= 1'b1;
      req_operation      <= op;
      req_request_size   <= size;
      req_payload_offset <= ptr;
      do @(posedge clock); while (busy);
      burst_left--;
      pred = serve_request(op, size, ptr);
      pending_rsp.push_back(typed ? typed_rsp : pred);
      // bookkeeping for pointer choice
      if (op == OP_RELEASE || (op == OP_RESIZE && size == 0) || (pred.moved))
         forget_live(ptr);
      if (pred.offset != 0 && pred.offset != ptr) begin
         live_blocks.push_back(pred.offset);
         prev_grant = last_grant;
         last_grant = pred.offset;
      end
   endtask

   // an offset that is rejected or null, or an aligned one whose header was written
   function automatic logic [15:0] noise_pointer();
      logic [15:0] p = 16'($urandom);
      if (p >= HDR_BYTES && p[2:0] == 3'd0 && !slot_written[(p - HDR_BYTES) >> 3]) p[0] = 1'b1;
      return p;
   endfunction

   function automatic logic [15:0] pick_pointer();
      int unsigned s, k = $urandom_range(0, 99);
      if (k < 75 && live_blocks.size() > 0)
         return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      if (k < 88) begin
         s = written_slots[$urandom_range(0, written_slots.size() - 1)];
         if (s < MAX_HDR_SLOT) return 16'((s << 3) + HDR_BYTES);
      end
      return noise_pointer();
   endfunction

   function automatic logic [16:0] pick_size();
      int unsigned k = $urandom_range(0, 99);
      if (k < 80) return 17'($urandom_range(0, 256));
      if (k < 95) return 17'($urandom_range(0, 4096));
      if (k < 98) return 17'($urandom_range(0, 65536));
      return 17'd65536;
   endfunction

   // result side: each strobe is compared with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("unexpected result transaction at t=%0t", $time);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status != want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_result_offset != want.offset)
               report_mismatch("result_offset", rsp_result_offset, want.offset);
            if (rsp_moved != want.moved) report_mismatch("moved", rsp_moved, want.moved);
            if (rsp_copy_length != want.copy)
               report_mismatch("copy_length", rsp_copy_length, want.copy);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      rsp_type typed_rsp;
      logic [15:0] p;
      int unsigned k;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_ALLOC;
      req_request_size = '0;
      req_payload_offset = '0;
      fail_count = 0;
      cycle_count = 0;
      burst_left = 0;
      last_grant = '0;
      prev_grant = '0;
      // shadow heap after reset: one free block spanning the heap
      foreach (blk_size[i]) begin
         blk_size[i] = 0; blk_next[i] = 0; blk_linked[i] = 0; blk_used[i] = 0;
         slot_written[i] = 0;
      end
      blk_size[0] = HEAP_BYTES - HDR_BYTES;
      slot_written[0] = 1'b1;
      written_slots.push_back(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (dir_tab[i]) begin
         case (dir_tab[i].sel)
            SEL_LAST: p = last_grant;
            SEL_PREV: p = prev_grant;
            default:  p = dir_tab[i].ptr;
         endcase
         typed_rsp = '{status: dir_tab[i].st, offset: dir_tab[i].off, moved: 1'b0, copy: 16'd0};
         issue(dir_tab[i].op, dir_tab[i].size, p, dir_tab[i].chk, typed_rsp);
      end

      // random part: mostly well-formed traffic on live blocks, some noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            // drain everything before carrying on
            start <= 1'b0;
            burst_left = 0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         k = $urandom_range(0, 99);
         if (live_blocks.size() > 40) k = 50 + k / 2;
         if (k < 45)      issue(OP_ALLOC, pick_size(), 16'($urandom), 1'b0, '0);
         else if (k < 72) issue(OP_RELEASE, 17'($urandom), pick_pointer(), 1'b0, '0);
         else if (k < 93) issue(OP_RESIZE, pick_size(), pick_pointer(), 1'b0, '0);
         else if (k < 96) issue(OP_UNKNOWN, 17'($urandom), 16'($urandom), 1'b0, '0);
         else             issue(2'($urandom_range(1, 2)), pick_size(), noise_pointer(), 1'b0, '0);
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ffha_pkg.sv
rtl/core/ffha_datapath.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator.sv
rtl/core/ffha_checker.sv
sim/tb_first_fit_heap_allocator.sv
